[rtl/jlr_pkg.sv]
`default_nettype none

package jlr_pkg;

    // Field widths of the item and result transactions.
    localparam int JOINT_W     = 5;
    localparam int POS_W       = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int ROW_W       = 5;
    localparam int COL_W       = 7;
    localparam int ROWCNT_W    = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam int JOINTS_DEFAULT = 32;
    localparam int FRONT_DEPTH    = 2;
    localparam int OUT_DEPTH      = 4;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_COLUMN = 3'd5;

    localparam logic        ENABLE_RST   = 1'b1;
    localparam logic [30:0] ALPHA_RST    = 31'd6554;
    localparam logic [30:0] DELTA_RST    = 31'd9830;
    localparam logic [30:0] EPS_RST      = 31'd7;
    localparam logic [30:0] GAIN_RST     = 31'd32768;
    localparam logic [5:0]  BASE_COL_RST = 6'd0;

    typedef enum logic [1:0] {
        ST_IN_PROGRESS = 2'd0,
        ST_INACTIVE    = 2'd1,
        ST_REPELLING   = 2'd2,
        ST_DISABLED    = 2'd3
    } status_t;

    typedef enum logic {
        ITEM_LIMITS = 1'b0,
        ITEM_SAMPLE = 1'b1
    } item_kind_t;

    typedef struct packed {
        item_kind_t                kind;
        logic                      in_range;
        logic [JOINT_W-1:0]        joint;
        logic signed [POS_W-1:0]   position;
        logic signed [POS_W-1:0]   lower;
        logic signed [POS_W-1:0]   upper;
        logic                      last;
    } front_item_t;

    typedef struct packed {
        logic        enable;
        logic [30:0] alpha;
        logic [31:0] delta_eff;
        logic [30:0] eps;
        logic [30:0] gain;
        logic [5:0]  base_column;
    } cfg_t;

    typedef struct packed {
        logic                          row_valid;
        logic [ROW_W-1:0]              row;
        logic [COL_W-1:0]              column;
        logic signed [VALUE_WIDTH-1:0] command;
        logic                          frame_end;
        status_t                       status;
    } result_t;

endpackage

`default_nettype wire

[rtl/joint_limit_repulsion.sv]
`default_nettype none

// Channel   Handshake            Payload
// items     push / full          op, joint, position, lower_limit, upper_limit, last_joint
// results   pop / empty          row_valid, row, column, command, frame_end, status
// config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item is accepted per cycle while the result queue has a free slot; every item gives one result.
// The rate is set by the per-joint flag read-modify-write done at issue, once a cycle.
// Issue is followed by a multiply stage and a round/saturate stage into the result queue.
// An item is held at the queue head when the result queue has no free reserved slot.
// rst_n clears the queues, limit tables, flags and row counter and sets the configuration to its reset values.

module joint_limit_repulsion
    import jlr_pkg::*;
#(
    parameter int JOINTS = JOINTS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          op,
    input  logic [JOINT_W-1:0]            joint,
    input  logic signed [POS_W-1:0]       position,
    input  logic signed [POS_W-1:0]       lower_limit,
    input  logic signed [POS_W-1:0]       upper_limit,
    input  logic                          last_joint,
    output logic                          empty,
    input  logic                          pop,
    output logic                          row_valid,
    output logic [ROW_W-1:0]              row,
    output logic [COL_W-1:0]              column,
    output logic signed [VALUE_WIDTH-1:0] command,
    output logic                          frame_end,
    output logic [1:0]                    status,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    logic        enable_reg;
    logic [30:0] alpha_reg;
    logic [30:0] delta_reg;
    logic [31:0] delta_eff_reg;
    logic [30:0] eps_reg;
    logic [30:0] gain_reg;
    logic [5:0]  base_col_reg;

    cfg_t        cfg;
    front_item_t item;
    logic        item_valid;
    logic        item_pop;
    result_t     result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= ENABLE_RST;
            alpha_reg     <= ALPHA_RST;
            delta_reg     <= DELTA_RST;
            delta_eff_reg <= 32'(DELTA_RST);
            eps_reg       <= EPS_RST;
            gain_reg      <= GAIN_RST;
            base_col_reg  <= BASE_COL_RST;
        end
        else
        begin
            // Release distance is kept at least one LSB above activation distance.
            delta_eff_reg <= (delta_reg <= alpha_reg) ? 32'(alpha_reg) + 32'd1
                                                      : 32'(delta_reg);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ENABLE:      enable_reg   <= cfg_data[0];
                    CFG_ALPHA:       alpha_reg    <= cfg_data[30:0];
                    CFG_DELTA:       delta_reg    <= cfg_data[30:0];
                    CFG_EPS:         eps_reg      <= cfg_data[30:0];
                    CFG_GAIN:        gain_reg     <= cfg_data[30:0];
                    CFG_BASE_COLUMN: base_col_reg <= cfg_data[5:0];
                    default:         ;
                endcase
            end
        end
    end

    always_comb
    begin
        cfg.enable      = enable_reg;
        cfg.alpha       = alpha_reg;
        cfg.delta_eff   = delta_eff_reg;
        cfg.eps         = eps_reg;
        cfg.gain        = gain_reg;
        cfg.base_column = base_col_reg;
    end

    jlr_front #(
        .JOINTS (JOINTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .op          (op),
        .joint       (joint),
        .position    (position),
        .lower_limit (lower_limit),
        .upper_limit (upper_limit),
        .last_joint  (last_joint),
        .item        (item),
        .item_valid  (item_valid),
        .item_pop    (item_pop)
    );

    jlr_back #(
        .JOINTS (JOINTS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .result     (result),
        .res_empty  (empty),
        .res_pop    (pop)
    );

    assign row_valid = result.row_valid;
    assign row       = result.row;
    assign column    = result.column;
    assign command   = result.command;
    assign frame_end = result.frame_end;
    assign status    = result.status;

endmodule

`default_nettype wire

[rtl/jlr_fifo.sv]
`default_nettype none

module jlr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic [WIDTH-1:0]                 wdata,
    output logic                             full,
    input  logic                             pop,
    output logic [WIDTH-1:0]                 rdata,
    output logic                             empty,
    output logic [$clog2(DEPTH+1)-1:0]       count
);

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTRW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTRW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNTW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTRW'(DEPTH-1)) ? '0 : wr_ptr_reg + PTRW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTRW'(DEPTH-1)) ? '0 : rd_ptr_reg + PTRW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNTW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

[rtl/jlr_front.sv]
`default_nettype none

module jlr_front
    import jlr_pkg::*;
#(
    parameter int JOINTS = JOINTS_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic                    op,
    input  logic [JOINT_W-1:0]      joint,
    input  logic signed [POS_W-1:0] position,
    input  logic signed [POS_W-1:0] lower_limit,
    input  logic signed [POS_W-1:0] upper_limit,
    input  logic                    last_joint,
    output front_item_t             item,
    output logic                    item_valid,
    input  logic                    item_pop
);

    localparam logic [6:0] JOINTS_L = 7'(JOINTS);

    front_item_t                       item_in;
    logic                              q_empty;
    logic [$clog2(FRONT_DEPTH+1)-1:0]  q_count;

    // Classify the transaction before it is queued.
    always_comb
    begin
        item_in.kind     = op ? ITEM_SAMPLE : ITEM_LIMITS;
        item_in.in_range = ({2'b00, joint} < JOINTS_L);
        item_in.joint    = joint;
        item_in.position = position;
        item_in.lower    = lower_limit;
        item_in.upper    = upper_limit;
        item_in.last     = last_joint;
    end

    jlr_fifo #(
        .WIDTH ($bits(front_item_t)),
        .DEPTH (FRONT_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (item_in),
        .full  (full),
        .pop   (item_pop),
        .rdata (item),
        .empty (q_empty),
        .count (q_count)
    );

    assign item_valid = !q_empty && (q_count != '0);

endmodule

`default_nettype wire

[rtl/jlr_back.sv]
`default_nettype none

module jlr_back
    import jlr_pkg::*;
#(
    parameter int JOINTS = JOINTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  front_item_t item,
    input  logic        item_valid,
    output logic        item_pop,
    output result_t     result,
    output logic        res_empty,
    input  logic        res_pop
);

    localparam int IDXW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int OCNT_W = $clog2(OUT_DEPTH+1);
    localparam int OCC_W  = $clog2(OUT_DEPTH+3);
    localparam logic [48:0] MAXPOS = 49'((64'd1 << (VALUE_WIDTH-1)) - 64'd1);

    typedef struct packed {
        item_kind_t         kind;
        logic               enable;
        logic               last;
        logic               has_cmd;
        logic               neg;
        logic [32:0]        mag;
        logic [COL_W-1:0]   column;
    } s1_t;

    typedef struct packed {
        item_kind_t         kind;
        logic               enable;
        logic               last;
        logic               has_cmd;
        logic               neg;
        logic [63:0]        prod;
        logic [COL_W-1:0]   column;
    } s2_t;

    logic signed [POS_W-1:0] lower_reg [JOINTS];
    logic signed [POS_W-1:0] upper_reg [JOINTS];
    logic [JOINTS-1:0]       lflag_reg;
    logic [JOINTS-1:0]       uflag_reg;
    logic [ROWCNT_W-1:0]     row_cnt_reg, row_cnt_next;

    logic s1_valid_reg, s2_valid_reg;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg;

    logic [OCNT_W-1:0] out_count;
    logic              out_full;
    logic [OCC_W-1:0]  occ;
    logic              issue;

    logic [6:0]         jx;
    logic [IDXW-1:0]    idx;
    logic signed [33:0] lo, hi, q, a, d, e;
    logic signed [33:0] diff_lo, diff_hi, diff;
    logic               active, lf0, uf0, lf1, uf1, lf2, uf2;

    // A result slot is reserved for every item in flight, so the result
    // queue can never overflow once an item is issued.
    assign occ   = OCC_W'(out_count) + OCC_W'(s1_valid_reg) + OCC_W'(s2_valid_reg);
    assign issue = item_valid && ((occ < OCC_W'(OUT_DEPTH)) || (res_pop && !res_empty));
    assign item_pop = issue;

    // Issue stage: table lookup and hysteresis update for the head item.
    always_comb
    begin
        jx  = {2'b00, item.joint};
        idx = jx[IDXW-1:0];
        lo  = 34'(lower_reg[idx]);
        hi  = 34'(upper_reg[idx]);
        q   = 34'(item.position);
        a   = 34'(cfg.alpha);
        d   = 34'(cfg.delta_eff);
        e   = 34'(cfg.eps);

        active = (item.kind == ITEM_SAMPLE) && cfg.enable && item.in_range && (hi > lo);

        lf0 = lflag_reg[idx];
        uf0 = uflag_reg[idx];
        lf1 = lf0 || (q < lo + a);
        lf2 = lf1 && !(q >= lo + d - e);
        uf1 = uf0 || (q > hi - a);
        uf2 = uf1 && !(q <= hi - d + e);

        diff_lo = lo + d - q;
        diff_hi = hi - d - q;
        diff    = lf2 ? diff_lo : diff_hi;

        s1_next.kind    = item.kind;
        s1_next.enable  = cfg.enable;
        s1_next.last    = item.last;
        s1_next.has_cmd = active && (lf2 || uf2);
        s1_next.neg     = diff[33];
        s1_next.mag     = diff[33] ? 33'(-diff) : diff[32:0];
        s1_next.column  = 7'(cfg.base_column) + 7'(item.joint);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < JOINTS; i++)
            begin
                lower_reg[i] <= '0;
                upper_reg[i] <= '0;
            end
            lflag_reg <= '0;
            uflag_reg <= '0;
        end
        else if (issue)
        begin
            if (item.kind == ITEM_LIMITS && item.in_range)
            begin
                lower_reg[idx] <= item.lower;
                upper_reg[idx] <= item.upper;
                lflag_reg[idx] <= 1'b0;
                uflag_reg[idx] <= 1'b0;
            end
            else if (active)
            begin
                lflag_reg[idx] <= lf2;
                uflag_reg[idx] <= uf2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            row_cnt_reg  <= '0;
        end
        else
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            if (s2_valid_reg)
            begin
                row_cnt_reg <= row_cnt_next;
            end
        end
    end

    // Multiply stage. The user must write the gain register only while no transaction is in flight (not enforced).
    always_ff @(posedge clk)
    begin
        s1_reg         <= s1_next;
        s2_reg.kind    <= s1_reg.kind;
        s2_reg.enable  <= s1_reg.enable;
        s2_reg.last    <= s1_reg.last;
        s2_reg.has_cmd <= s1_reg.has_cmd;
        s2_reg.neg     <= s1_reg.neg;
        s2_reg.prod    <= 64'(s1_reg.mag) * 64'(cfg.gain);
        s2_reg.column  <= s1_reg.column;
    end

    // Round, saturate and number the row.
    logic [48:0]                  r;
    logic signed [VALUE_WIDTH-1:0] cmd;
    logic                         cmd_valid;
    logic [ROWCNT_W-1:0]          cnt_inc;
    result_t                      res_in;

    always_comb
    begin
        r = {1'b0, s2_reg.prod[63:16]} + 49'(s2_reg.prod[15]);
        if (s2_reg.neg)
        begin
            cmd = (r > MAXPOS) ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                               : VALUE_WIDTH'(0) - r[VALUE_WIDTH-1:0];
        end
        else
        begin
            cmd = (r > MAXPOS) ? MAXPOS[VALUE_WIDTH-1:0] : r[VALUE_WIDTH-1:0];
        end
        cmd_valid = s2_reg.has_cmd && (r != '0);
        cnt_inc   = (cmd_valid && row_cnt_reg != {ROWCNT_W{1'b1}})
                    ? row_cnt_reg + ROWCNT_W'(1) : row_cnt_reg;

        res_in       = '0;
        row_cnt_next = row_cnt_reg;
        if (s2_reg.kind == ITEM_SAMPLE)
        begin
            res_in.frame_end = s2_reg.last;
            if (!s2_reg.enable)
            begin
                res_in.status = ST_DISABLED;
                row_cnt_next  = s2_reg.last ? '0 : row_cnt_reg;
            end
            else
            begin
                if (cmd_valid)
                begin
                    res_in.row_valid = 1'b1;
                    res_in.row       = row_cnt_reg[ROW_W-1:0];
                    res_in.column    = s2_reg.column;
                    res_in.command   = cmd;
                end
                if (s2_reg.last)
                begin
                    res_in.status = (cnt_inc != '0) ? ST_REPELLING : ST_INACTIVE;
                    row_cnt_next  = '0;
                end
                else
                begin
                    res_in.status = ST_IN_PROGRESS;
                    row_cnt_next  = cnt_inc;
                end
            end
        end
    end

    jlr_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_results (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (s2_valid_reg),
        .wdata (res_in),
        .full  (out_full),
        .pop   (res_pop),
        .rdata (result),
        .empty (res_empty),
        .count (out_count)
    );

endmodule

`default_nettype wire

[rtl/jlr_checker.sv]
`default_nettype none

module jlr_checker
    import jlr_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          empty,
    input  logic                          pop,
    input  logic                          row_valid,
    input  logic [ROW_W-1:0]              row,
    input  logic [COL_W-1:0]              column,
    input  logic signed [VALUE_WIDTH-1:0] command,
    input  logic                          frame_end,
    input  logic [1:0]                    status
);

    // A result without a row carries no row number, column or command.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !row_valid) |-> (row == '0 && column == '0 && command == '0))
        else $error("result without a row carries payload");

    // A row always holds a nonzero command and never comes from a disabled sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && row_valid) |-> (command != '0 && status != ST_DISABLED &&
                                   status != ST_INACTIVE))
        else $error("row with zero command or wrong status");

    // Frame status appears exactly on frame ends, disabled status aside.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (frame_end ? (status != ST_IN_PROGRESS)
                              : (status == ST_IN_PROGRESS || status == ST_DISABLED)))
        else $error("status does not match frame end");

    // A waiting result holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(command) && $stable(status)))
        else $error("waiting result changed");

endmodule

bind joint_limit_repulsion jlr_checker u_checker (.*);

`default_nettype wire
